@@ rtl/ptbl_pkg.sv @@
package ptbl_pkg;

   // Field widths
   localparam int CLIENT_W = 12;
   localparam int TIME_W   = 32;
   localparam int BURST_W  = 8;
   localparam int RATE_W   = 24;
   localparam int LEVEL_W  = 24;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = TIME_W + RATE_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int ENTRY_W  = 1 + TIME_W + LEVEL_W;

   // Stream word widths, padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_TOKENS    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFILL_PER_TICK = 8'd1;

   localparam logic [BURST_W-1:0] BURST_RESET  = 8'd180;
   localparam logic [RATE_W-1:0]  REFILL_RESET = 24'd786;

   localparam logic [LEVEL_W-1:0] ONE_TOKEN = 24'h01_0000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_ADD,
      ST_SAT
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic reduce;
      logic rd_en;
      logic diff;
      logic mul;
      logic add;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic need_reduce;
      logic out_free;
   } status_type;

endpackage

@@ rtl/ptbl_ram.sv @@
module ptbl_ram #(
   parameter int WIDTH = 57,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ptbl_ctrl.sv @@
module ptbl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ptbl_pkg::status_type status,
   output ptbl_pkg::cmd_type    cmd
);

   ptbl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptbl_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptbl_pkg::ST_CLEAR: begin
            if (status.clr_done) state_in = ptbl_pkg::ST_IDLE;
         end
         ptbl_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.need_reduce ? ptbl_pkg::ST_REDUCE : ptbl_pkg::ST_READ;
            end
         end
         ptbl_pkg::ST_REDUCE: state_in = ptbl_pkg::ST_READ;
         ptbl_pkg::ST_READ: state_in = ptbl_pkg::ST_DIFF;
         ptbl_pkg::ST_DIFF: state_in = ptbl_pkg::ST_MUL;
         ptbl_pkg::ST_MUL:  state_in = ptbl_pkg::ST_ADD;
         ptbl_pkg::ST_ADD:  state_in = ptbl_pkg::ST_SAT;
         ptbl_pkg::ST_SAT: begin
            if (status.out_free) state_in = ptbl_pkg::ST_IDLE;
         end
         default: state_in = ptbl_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ptbl_pkg::ST_CLEAR:  cmd.clear = 1'b1;
         ptbl_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ptbl_pkg::ST_REDUCE: cmd.reduce = 1'b1;
         ptbl_pkg::ST_READ:   cmd.rd_en  = 1'b1;
         ptbl_pkg::ST_DIFF:   cmd.diff   = 1'b1;
         ptbl_pkg::ST_MUL:    cmd.mul    = 1'b1;
         ptbl_pkg::ST_ADD:    cmd.add    = 1'b1;
         ptbl_pkg::ST_SAT:    cmd.commit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/ptbl_dp.sv @@
module ptbl_dp #(
   parameter int NUM_CLIENTS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ptbl_pkg::CLIENT_W-1:0]       req_client_index,
   input  logic [ptbl_pkg::TIME_W-1:0]         req_now_ticks,
   input  logic                                csr_valid,
   input  logic [ptbl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ptbl_pkg::CSR_DATA_W-1:0]     csr_data,
   input  ptbl_pkg::cmd_type                   cmd,
   output ptbl_pkg::status_type                status,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic                                rsp_allowed,
   output logic [ptbl_pkg::BURST_W-1:0]        rsp_tokens_whole
);

   localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam logic [31:0]      NUM_W    = 32'(NUM_CLIENTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CLIENTS - 1);
   // Reciprocal of NUM_CLIENTS, exact floor quotient for any 12-bit index
   localparam int          RED_SHIFT = ptbl_pkg::CLIENT_W + IDX_W;
   localparam logic [31:0] RED_MAGIC =
      32'(((64'd1 << RED_SHIFT) + 64'(NUM_CLIENTS) - 64'd1) / 64'(NUM_CLIENTS));

   logic [ptbl_pkg::BURST_W-1:0]  burst_ff;
   logic [ptbl_pkg::RATE_W-1:0]   refill_ff;
   logic [IDX_W-1:0]              clr_addr_ff;
   logic [ptbl_pkg::CLIENT_W-1:0] rem_ff, rem_in;
   logic [ptbl_pkg::TIME_W-1:0]   now_ff;
   logic [ptbl_pkg::TIME_W-1:0]   elapsed_ff;
   logic [ptbl_pkg::PROD_W-1:0]   product_ff;
   logic [ptbl_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                          rsp_valid_ff;
   logic                          allowed_ff;
   logic [ptbl_pkg::BURST_W-1:0]  tokens_ff;

   logic [ptbl_pkg::ENTRY_W-1:0]  rd_data;
   logic [ptbl_pkg::ENTRY_W-1:0]  wr_data;
   logic [IDX_W-1:0]              idx;
   logic [IDX_W-1:0]              wr_addr;
   logic [ptbl_pkg::LEVEL_W-1:0]  rd_level;
   logic [ptbl_pkg::TIME_W-1:0]   rd_time;
   logic                          rd_valid;
   logic [31:0]                   red_prod;
   logic [31:0]                   red_quot;
   logic [31:0]                   red_back;
   logic [ptbl_pkg::LEVEL_W-1:0]  cap;
   logic [ptbl_pkg::LEVEL_W-1:0]  clamped;
   logic [ptbl_pkg::LEVEL_W-1:0]  level_new;
   logic                          ok;

   assign idx      = IDX_W'(rem_ff);
   assign rd_level = rd_data[ptbl_pkg::LEVEL_W-1:0];
   assign rd_time  = rd_data[ptbl_pkg::LEVEL_W +: ptbl_pkg::TIME_W];
   assign rd_valid = rd_data[ptbl_pkg::ENTRY_W-1];
   assign cap      = {burst_ff, {ptbl_pkg::FRAC_W{1'b0}}};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff  <= ptbl_pkg::BURST_RESET;
         refill_ff <= ptbl_pkg::REFILL_RESET;
      end else if (csr_valid) begin
         if (csr_index == ptbl_pkg::CSR_BURST_TOKENS) begin
            burst_ff <= csr_data[ptbl_pkg::BURST_W-1:0];
         end else if (csr_index == ptbl_pkg::CSR_REFILL_PER_TICK) begin
            refill_ff <= csr_data[ptbl_pkg::RATE_W-1:0];
         end
      end
   end

   // Clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // Index folding: quotient by reciprocal multiplication, then subtract
   // quotient times NUM_CLIENTS to leave the remainder
   assign red_prod = 32'(rem_ff) * RED_MAGIC;
   assign red_quot = red_prod >> RED_SHIFT;
   assign red_back = red_quot * NUM_W;

   always_comb begin
      rem_in = rem_ff;
      if (cmd.capture) begin
         rem_in = req_client_index;
      end else if (cmd.reduce) begin
         rem_in = rem_ff - red_back[ptbl_pkg::CLIENT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (cmd.capture) begin
         now_ff <= req_now_ticks;
      end
   end

   // Refill arithmetic
   always_comb begin
      if (rd_valid) begin
         sum_in = ptbl_pkg::SUM_W'(rd_level) + ptbl_pkg::SUM_W'(product_ff);
      end else begin
         sum_in = ptbl_pkg::SUM_W'(cap);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) elapsed_ff <= now_ff - rd_time;
      if (cmd.mul)  product_ff <= elapsed_ff * refill_ff;
      if (cmd.add)  sum_ff     <= sum_in;
   end

   // Saturate, then take a token if a whole one is there
   assign clamped   = (sum_ff > ptbl_pkg::SUM_W'(cap)) ? cap
                      : sum_ff[ptbl_pkg::LEVEL_W-1:0];
   assign ok        = clamped >= ptbl_pkg::ONE_TOKEN;
   assign level_new = ok ? clamped - ptbl_pkg::ONE_TOKEN : clamped;

   assign wr_addr = cmd.clear ? clr_addr_ff : idx;
   assign wr_data = cmd.clear ? '0 : {1'b1, now_ff, level_new};

   ptbl_ram #(
      .WIDTH (ptbl_pkg::ENTRY_W),
      .DEPTH (NUM_CLIENTS)
   ) u_bucket_ram (
      .clock   (clock),
      .wr_en   (cmd.clear | cmd.commit),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         allowed_ff <= ok;
         tokens_ff  <= level_new[ptbl_pkg::LEVEL_W-1:ptbl_pkg::FRAC_W];
      end
   end

   assign status.clr_done    = clr_addr_ff == LAST_IDX;
   assign status.need_reduce = {20'b0, req_client_index} >= NUM_W;
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_allowed      = allowed_ff;
   assign rsp_tokens_whole = tokens_ff;

endmodule

@@ rtl/per_client_token_bucket_limiter.sv @@
// Sequence: once a request word is accepted, a fold step runs first when the client index
// is NUM_CLIENTS or more (one reciprocal-multiply step folds it into range), then come the
// read, difference, multiply, add and saturate steps around one RAM, and the result word is
// registered. One request at a time is taken through these steps; a held result word stalls it.
// Reset: synchronous, active high; registers return to 180 tokens and 786/65536 per tick,
// then a clearing pass marks all NUM_CLIENTS buckets unused (read as full) before requests.
module per_client_token_bucket_limiter #(
   parameter int NUM_CLIENTS = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ptbl_pkg::REQ_DATA_W-1:0]       req_tdata,  // client_index[11:0], now_ticks[43:12]
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ptbl_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // allowed[0], tokens_whole[8:1]
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ptbl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ptbl_pkg::CSR_DATA_W-1:0]       csr_data
);

   ptbl_pkg::cmd_type    cmd;
   ptbl_pkg::status_type status;

   logic                         rsp_allowed;
   logic [ptbl_pkg::BURST_W-1:0] rsp_tokens_whole;

   // Configuration is always taken; user must keep the block idle when it is written, unenforced.
   assign csr_ready = 1'b1;

   // Sequencer: clear sweep, then one request at a time through the datapath.
   ptbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Bucket store, refill arithmetic and the result register.
   ptbl_dp #(
      .NUM_CLIENTS (NUM_CLIENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_client_index (req_tdata[ptbl_pkg::CLIENT_W-1:0]),
      .req_now_ticks    (req_tdata[ptbl_pkg::CLIENT_W +: ptbl_pkg::TIME_W]),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_allowed      (rsp_allowed),
      .rsp_tokens_whole (rsp_tokens_whole)
   );

   // Pack the result word; pad the upper bits with zeros.
   assign rsp_tdata = {{(ptbl_pkg::RSP_DATA_W - ptbl_pkg::BURST_W - 1){1'b0}},
                       rsp_tokens_whole, rsp_allowed};

endmodule

@@ tb/sv/tb_per_client_token_bucket_limiter.sv @@
`timescale 1ns / 100ps

module tb_per_client_token_bucket_limiter;

   localparam int TB_CLIENTS = 4096;
   localparam int PROBE_N    = 24;
   localparam int PHASES     = 6;
   localparam int PHASE_LEN  = 125;
   localparam int HOLD_LEN   = 400;
   localparam int VQ_DEPTH   = 64;

   // one admission decision as it leaves the block
   typedef struct packed {
      logic       allowed;
      logic [7:0] tokens;
   } verdict_type;

   // directed probe: optional register change, one request, and the verdict
   // where it can be stated by hand (typed), otherwise left to the predictor
   typedef struct packed {
      logic        reprogram;
      logic [7:0]  burst;
      logic [23:0] rate;
      logic [11:0] client;
      logic [31:0] now;
      logic        typed;
      logic        allowed;
      logic [7:0]  tokens;
   } probe_row_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ptbl_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ptbl_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [ptbl_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [ptbl_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   // shadow of the limiter: registers and per-client buckets
   logic [7:0]  burst_cfg = ptbl_pkg::BURST_RESET;
   logic [23:0] rate_cfg  = ptbl_pkg::REFILL_RESET;
   logic [23:0] bkt_level [TB_CLIENTS];
   logic [31:0] bkt_time  [TB_CLIENTS];
   bit          bkt_valid [TB_CLIENTS];

   // predicted verdicts in acceptance order, as a ring
   verdict_type verdict_ring [VQ_DEPTH];
   int          vq_head       = 0;     // oldest verdict not yet compared
   int          vq_tail       = 0;     // next free slot
   int          mismatches    = 0;
   bit          steady_flow   = 1'b0;  // no idling on either side while set
   int          hold_requests = 0;     // bumped by the sender to ask for a long stall
   int          hold_granted  = 0;
   int          hold_left     = 0;

   probe_row_type probe_rows [PROBE_N] = '{
      // reset registers: first fill, extremes of index and time
      '{1'b0, 8'd0,   24'd0,       12'h000, 32'h0000_0000, 1'b1, 1'b1, 8'd179},
      '{1'b0, 8'd0,   24'd0,       12'hFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd179},
      '{1'b0, 8'd0,   24'd0,       12'h000, 32'h0000_0001, 1'b0, 1'b0, 8'd0},
      // time running backwards looks like a long gap: refill to capacity
      '{1'b0, 8'd0,   24'd0,       12'h000, 32'h0000_0000, 1'b1, 1'b1, 8'd179},
      '{1'b0, 8'd0,   24'd0,       12'hFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'hAAA, 32'h5555_5555, 1'b1, 1'b1, 8'd179},
      '{1'b0, 8'd0,   24'd0,       12'h555, 32'hAAAA_AAAA, 1'b1, 1'b1, 8'd179},
      // single-token bucket, no refill: drain and stay empty
      '{1'b1, 8'd1,   24'd0,       12'h001, 32'd100,       1'b1, 1'b1, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'h001, 32'd200,       1'b1, 1'b0, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'h001, 32'd1,         1'b1, 1'b0, 8'd0},
      // lowered burst clamps a full bucket down
      '{1'b0, 8'd0,   24'd0,       12'h000, 32'd5,         1'b1, 1'b1, 8'd0},
      // zero burst rejects everything
      '{1'b1, 8'd0,   24'd786,     12'h002, 32'd7,         1'b1, 1'b0, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'h000, 32'd9,         1'b1, 1'b0, 8'd0},
      // widest burst and fastest refill
      '{1'b1, 8'd255, 24'hFF_FFFF, 12'h003, 32'd0,         1'b1, 1'b1, 8'd254},
      '{1'b0, 8'd0,   24'd0,       12'h003, 32'd1,         1'b1, 1'b1, 8'd254},
      '{1'b0, 8'd0,   24'd0,       12'h003, 32'd1,         1'b1, 1'b1, 8'd253},
      '{1'b0, 8'd0,   24'd0,       12'h003, 32'd1,         1'b1, 1'b1, 8'd252},
      '{1'b0, 8'd0,   24'd0,       12'h000, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd254},
      // quarter token per tick: run dry, then earn one token back
      '{1'b1, 8'd4,   24'd16384,   12'h007, 32'd1000,      1'b1, 1'b1, 8'd3},
      '{1'b0, 8'd0,   24'd0,       12'h007, 32'd1000,      1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'h007, 32'd1000,      1'b0, 1'b0, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'h007, 32'd1000,      1'b1, 1'b1, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'h007, 32'd1000,      1'b1, 1'b0, 8'd0},
      '{1'b0, 8'd0,   24'd0,       12'h007, 32'd1004,      1'b0, 1'b0, 8'd0}
   };

   per_client_token_bucket_limiter #(
      .NUM_CLIENTS (TB_CLIENTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // client_index[11:0], now_ticks[43:12]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // allowed[0], tokens_whole[8:1]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Refill the named bucket up to now, take a token if one is whole, and
   // return the verdict. Updates the shadow buckets as the block would.
   function automatic verdict_type charge_bucket(input logic [11:0] client,
                                                 input logic [31:0] now);
      int          slot;
      logic [31:0] elapsed;
      logic [56:0] cap;
      logic [56:0] fill;
      verdict_type v;
      slot = int'(client) % TB_CLIENTS;
      cap  = 57'(burst_cfg) << ptbl_pkg::FRAC_W;
      if (!bkt_valid[slot]) begin
         fill = cap;
      end else begin
         elapsed = now - bkt_time[slot];
         fill    = 57'(bkt_level[slot]) + 57'(elapsed) * 57'(rate_cfg);
      end
      if (fill > cap) begin
         fill = cap;
      end
      v.allowed = (fill >= 57'(ptbl_pkg::ONE_TOKEN));
      if (v.allowed) begin
         fill = fill - 57'(ptbl_pkg::ONE_TOKEN);
      end
      bkt_level[slot] = fill[23:0];
      bkt_time[slot]  = now;
      bkt_valid[slot] = 1'b1;
      v.tokens        = fill[23:16];
      return v;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s", msg);
      end
   endtask

   // Offer one request word; idle first now and then. Valid stays high on
   // return so back-to-back words never drop it.
   task automatic offer_request(input logic [11:0] client, input logic [31:0] now,
                                input logic typed, input verdict_type typed_v);
      verdict_type v;
      if (!steady_flow && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!steady_flow && $urandom_range(0, 99) < 15);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, now, client};
      do @(posedge clock); while (!req_tready);
      // accepted at this edge: predict in acceptance order
      v = charge_bucket(client, now);
      if (typed) begin
         v = typed_v;
      end
      verdict_ring[vq_tail % VQ_DEPTH] = v;
      vq_tail++;
   endtask

   // Drop valid and wait for every outstanding verdict.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (vq_tail != vq_head) @(posedge clock);
   endtask

   // Write both registers with the block idle; valid stays high across them.
   task automatic program_limits(input logic [7:0] burst, input logic [23:0] rate);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= ptbl_pkg::CSR_BURST_TOKENS;
      csr_data  <= {24'b0, burst};
      do @(posedge clock); while (!csr_ready);
      burst_cfg = burst;
      csr_index <= ptbl_pkg::CSR_REFILL_PER_TICK;
      csr_data  <= {8'b0, rate};
      do @(posedge clock); while (!csr_ready);
      rate_cfg = rate;
      csr_valid <= 1'b0;
   endtask

   // Result side: random back-pressure, plus a long stall on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_granted != hold_requests) begin
         hold_granted <= hold_granted + 1;
         hold_left    <= HOLD_LEN;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 15);
      end
   end

   // Compare each result word with the oldest predicted verdict.
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.allowed = rsp_tdata[0];
         got.tokens  = rsp_tdata[8:1];
         if (vq_tail == vq_head) begin
            note_mismatch($sformatf("%0t: unexpected result word allowed=%0b tokens=%0d",
                                    $time, got.allowed, got.tokens));
         end else begin
            want = verdict_ring[vq_head % VQ_DEPTH];
            vq_head++;
            if (got.allowed !== want.allowed) begin
               note_mismatch($sformatf("%0t: allowed expected %0b got %0b",
                                       $time, want.allowed, got.allowed));
            end
            if (got.tokens !== want.tokens) begin
               note_mismatch($sformatf("%0t: tokens_whole expected %0d got %0d",
                                       $time, want.tokens, got.tokens));
            end
         end
      end
   end

   initial begin
      verdict_type typed_v;
      verdict_type none_v;
      logic [7:0]  burst;
      logic [23:0] rate;
      logic [11:0] pool [6];
      logic [11:0] client;
      logic [31:0] now;
      logic [31:0] tick_now;
      int          roll;

      none_v = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed probes: reset values first, then the corner settings.
      for (int r = 0; r < PROBE_N; r++) begin
         if (probe_rows[r].reprogram) begin
            program_limits(probe_rows[r].burst, probe_rows[r].rate);
         end
         typed_v.allowed = probe_rows[r].allowed;
         typed_v.tokens  = probe_rows[r].tokens;
         offer_request(probe_rows[r].client, probe_rows[r].now,
                       probe_rows[r].typed, typed_v);
      end

      // Random phases: mostly a handful of busy clients on a slowly advancing
      // clock, so buckets run dry and refill; the rest is noise and clock
      // steps backwards.
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0) begin
            burst = ptbl_pkg::BURST_RESET;
            rate  = ptbl_pkg::REFILL_RESET;
         end else begin
            case ($urandom_range(0, 4))
               0:       burst = 8'd0;
               1:       burst = 8'd255;
               default: burst = 8'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 5))
               0:       rate = 24'd0;
               1:       rate = 24'hFF_FFFF;
               2:       rate = 24'($urandom);
               default: rate = 24'($urandom_range(0, 12000));
            endcase
         end
         // pausing here until all verdicts are in covers the sender-side hold
         program_limits(burst, rate);
         steady_flow = (ph == 3);
         for (int k = 0; k < 6; k++) begin
            pool[k] = 12'($urandom_range(0, TB_CLIENTS - 1));
         end
         tick_now = (ph == 4) ? 32'hFFFF_FF00 : $urandom;

         for (int n = 0; n < PHASE_LEN; n++) begin
            // stall the result side for a long stretch; keep offering words
            if (ph == 2 && n == 20) begin
               hold_requests++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               client = 12'($urandom_range(0, TB_CLIENTS - 1));
               now    = $urandom;
            end else if (roll < 11) begin
               client = pool[$urandom_range(0, 5)];
               now    = tick_now - 32'($urandom_range(1, 50));
            end else begin
               if ($urandom_range(0, 9) == 0) begin
                  tick_now = tick_now + 32'($urandom_range(0, 5000));
               end else begin
                  tick_now = tick_now + 32'($urandom_range(0, 2));
               end
               client = pool[$urandom_range(0, 5)];
               now    = tick_now;
            end
            offer_request(client, now, 1'b0, none_v);
         end
      end
      steady_flow = 1'b0;

      drain_results();
      // allow any stray word to show up
      repeat (40) @(posedge clock);
      if (mismatches == 0 && vq_tail == vq_head) begin
         $display("per_client_token_bucket_limiter test passed");
      end else begin
         $display("per_client_token_bucket_limiter test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, clearing pass included.
   initial begin
      #5_000_000;
      $display("per_client_token_bucket_limiter test failed");
      $finish;
   end

endmodule
